@@ design/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Shared op codes, field widths and arithmetic constants of the periodic
// task tick scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pts_pkg;

    localparam int OP_W          = 2;
    localparam int INTERVAL_MS_W = 16;
    localparam int TASK_IDX_W    = 3;
    localparam int SECONDS_W     = 25;
    localparam int LOAD_W        = 32;
    localparam int TICK_W        = 32;
    localparam int PERIOD_W      = 14;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
    localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;

    // ticks = (ms * 16 + 62) / 125, the divide done as a reciprocal multiply
    localparam int CONV_IN_W    = INTERVAL_MS_W + 5;
    localparam int CONV_MUL_W   = 22;
    localparam int CONV_SHIFT   = 28;
    localparam logic [CONV_MUL_W-1:0] CONV_MUL = 22'd2147484;
    localparam logic [CONV_IN_W-1:0]  CONV_ROUND = 21'd62;

    localparam int SEC_SHIFT    = 7;
    localparam int MAX_DISPATCH = 8;
    localparam int FOUND_W      = 4;

    localparam logic [LOAD_W-1:0] LOAD_BASE     = 32'd64;
    localparam logic [LOAD_W-1:0] LOAD_PER_TASK = 32'd26;

endpackage

@@ design/pts_period_conv.sv @@
// ----------------------------------------------------------------------------
// pts_period_conv
// Converts a period in milliseconds to 1/128 s ticks, rounded to nearest,
// with one register after the multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pts_period_conv
    import pts_pkg::*;
(
    input  logic                     aclk,
    input  logic [INTERVAL_MS_W-1:0] interval_ms,
    output logic [PERIOD_W-1:0]      period_ticks
);

    localparam int PROD_W = CONV_IN_W + CONV_MUL_W;

    logic [CONV_IN_W-1:0] scaled;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;

    assign scaled    = {1'b0, interval_ms, 4'b0000} + CONV_ROUND;
    assign prod_next = PROD_W'(scaled) * PROD_W'(CONV_MUL);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign period_ticks = prod_reg[CONV_SHIFT +: PERIOD_W];

endmodule

@@ design/periodic_task_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Table of periodic tasks advanced by a 1/128 s tick, with task add and
// in-order dispatch of ready tasks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_op, s_interval_ms
//  m_      | out       | m_valid / m_ready | m_accepted, m_task_valid, m_task_index,
//          |           |                   | m_last, m_seconds, m_load_estimate
//
//  one word at a time; a single sequencer walks the task table one entry a cycle while the m_ side does not stall it
//  tick: the sequencer walks every registered task, then the result word
//  add: through the period multiplier's register, then the result word
//  service: a scan of the registered tasks, then a walk over the slots up to the
//  last ready one, each ready slot emitting a word (one empty word when none is ready)
//  reset is synchronous active low; the task table holds no reset and is written on add
//  a stalled m_ side holds the sequencer in its result or emit step; s_ready is low meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top
    import pts_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [INTERVAL_MS_W-1:0] s_interval_ms,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_accepted,
    output logic                     m_task_valid,
    output logic [TASK_IDX_W-1:0]    m_task_index,
    output logic                     m_last,
    output logic [SECONDS_W-1:0]     m_seconds,
    output logic [LOAD_W-1:0]        m_load_estimate
);

    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W = $clog2(TASKS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_CONV   = 3'd2;
    localparam logic [2:0] S_SVC    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FOUND_W-1:0]    found_reg, found_next;
    logic [TASKS-1:0]      pick_reg, pick_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [LOAD_W-1:0]     load_reg, load_next;
    logic                  res_acc_reg, res_acc_next;
    logic [CNT_W-1:0]      res_idx_reg, res_idx_next;

    logic [PERIOD_W-1:0]   task_period_reg  [TASKS];
    logic [PERIOD_W-1:0]   task_counter_reg [TASKS];
    logic [TASKS-1:0]      task_ready_reg;

    logic                  m_valid_reg;
    logic                  m_accepted_reg;
    logic                  m_task_valid_reg;
    logic [TASK_IDX_W-1:0] m_task_index_reg;
    logic                  m_last_reg;
    logic [SECONDS_W-1:0]  m_seconds_reg;
    logic [LOAD_W-1:0]     m_load_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  out_acc;
    logic                  out_tv;
    logic [CNT_W-1:0]      out_idx;
    logic                  out_last;

    logic [IDX_W-1:0]      ptr_idx;
    logic [IDX_W-1:0]      cnt_idx;
    logic [TASKS-1:0]      ptr_sel;
    logic                  scan_end;
    logic                  hit;
    logic [PERIOD_W-1:0]   counter_inc;
    logic [PERIOD_W-1:0]   conv_ticks;

    pts_period_conv u_conv (
        .aclk         (aclk),
        .interval_ms  (s_interval_ms),
        .period_ticks (conv_ticks)
    );

    assign ptr_idx     = ptr_reg[IDX_W-1:0];
    assign cnt_idx     = cnt_reg[IDX_W-1:0];
    assign ptr_sel     = TASKS'(1) << ptr_idx;
    assign scan_end    = (CNT_W'(ptr_reg + 1'b1) == cnt_reg);
    assign hit         = task_ready_reg[ptr_idx];
    assign counter_inc = task_counter_reg[ptr_idx] + 1'b1;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        tick_next    = tick_reg;
        load_next    = load_reg;
        res_acc_next = res_acc_reg;
        res_idx_next = res_idx_reg;
        out_load     = 1'b0;
        out_acc      = 1'b0;
        out_tv       = 1'b0;
        out_idx      = '0;
        out_last     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ptr_next     = '0;
                    found_next   = '0;
                    pick_next    = '0;
                    res_acc_next = 1'b0;
                    res_idx_next = '0;
                    unique case (s_op)
                        OP_TICK: begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = (cnt_reg == '0) ? S_RESULT : S_TICK;
                        end
                        OP_ADD: begin
                            state_next = (cnt_reg >= CNT_W'(TASKS)) ? S_RESULT : S_CONV;
                        end
                        OP_SERVICE: begin
                            load_next  = load_reg + LOAD_BASE
                                       + LOAD_PER_TASK * LOAD_W'(cnt_reg);
                            state_next = (cnt_reg == '0) ? S_EMIT : S_SVC;
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_TICK: begin
                ptr_next = CNT_W'(ptr_reg + 1'b1);
                if (scan_end) begin
                    state_next = S_RESULT;
                end
            end
            S_CONV: begin
                res_acc_next = 1'b1;
                res_idx_next = cnt_reg;
                cnt_next     = CNT_W'(cnt_reg + 1'b1);
                state_next   = S_RESULT;
            end
            S_SVC: begin
                if (hit) begin
                    pick_next[ptr_idx] = 1'b1;
                    found_next         = FOUND_W'(found_reg + 1'b1);
                end
                if (scan_end || (hit && (FOUND_W'(found_reg + 1'b1) == FOUND_W'(MAX_DISPATCH))))
                begin
                    ptr_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
            end
            S_EMIT: begin
                if (pick_reg == '0) begin
                    // nothing ready: a single empty word
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (pick_reg[ptr_idx]) begin
                    if (out_free) begin
                        out_load           = 1'b1;
                        out_tv             = 1'b1;
                        out_idx            = ptr_reg;
                        out_last           = ((pick_reg & ~ptr_sel) == '0);
                        pick_next[ptr_idx] = 1'b0;
                        ptr_next           = CNT_W'(ptr_reg + 1'b1);
                        if (out_last) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_acc    = res_acc_reg;
                    out_idx    = res_idx_reg;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            found_reg   <= '0;
            pick_reg    <= '0;
            tick_reg    <= '0;
            load_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            pick_reg  <= pick_next;
            tick_reg  <= tick_next;
            load_reg  <= load_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload and task table
    always_ff @(posedge aclk) begin
        res_acc_reg <= res_acc_next;
        res_idx_reg <= res_idx_next;
        if (out_load) begin
            m_accepted_reg   <= out_acc;
            m_task_valid_reg <= out_tv;
            m_task_index_reg <= TASK_IDX_W'(out_idx);
            m_last_reg       <= out_last;
            m_seconds_reg    <= tick_reg[SEC_SHIFT +: SECONDS_W];
            m_load_reg       <= load_reg;
        end
        if (state_reg == S_TICK) begin
            if (counter_inc >= task_period_reg[ptr_idx]) begin
                task_counter_reg[ptr_idx] <= '0;
                task_ready_reg[ptr_idx]   <= 1'b1;
            end else begin
                task_counter_reg[ptr_idx] <= counter_inc;
            end
        end
        if (state_reg == S_CONV) begin
            task_period_reg[cnt_idx]  <= conv_ticks;
            task_counter_reg[cnt_idx] <= '0;
            task_ready_reg[cnt_idx]   <= 1'b0;
        end
        if ((state_reg == S_SVC) && hit) begin
            task_ready_reg[ptr_idx] <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_task_valid    = m_task_valid_reg;
    assign m_task_index    = m_task_index_reg;
    assign m_last          = m_last_reg;
    assign m_seconds       = m_seconds_reg;
    assign m_load_estimate = m_load_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TASKS))
        else $error("task count beyond table size");

    a_pick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(pick_reg) <= MAX_DISPATCH)
        else $error("more tasks picked than one service may dispatch");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_task_valid |-> !m_accepted)
        else $error("dispatch word flagged as accepted add");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && (state_next == S_IDLE) |=> pick_reg == '0)
        else $error("service finished with picked tasks left over");

endmodule

@@ tb/sched_checker.sv @@
// ----------------------------------------------------------------------------
// sched_checker
// Watches both channels of the periodic task tick scheduler. It keeps its own
// copy of the task table, works out the result words of every accepted input
// word, and compares them in order with the words that leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sched_checker
    import pts_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [INTERVAL_MS_W-1:0] s_interval_ms,

    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_accepted,
    input  logic                     m_task_valid,
    input  logic [TASK_IDX_W-1:0]    m_task_index,
    input  logic                     m_last,
    input  logic [SECONDS_W-1:0]     m_seconds,
    input  logic [LOAD_W-1:0]        m_load_estimate,

    output int                       fail_count,
    output int                       words_pending
);

    typedef struct packed {
        logic                  accepted;
        logic                  task_valid;
        logic [TASK_IDX_W-1:0] task_index;
        logic                  last;
        logic [SECONDS_W-1:0]  seconds;
        logic [LOAD_W-1:0]     load_estimate;
    } sched_word_t;

    sched_word_t         due_words[$];
    int                  mismatches;

    logic [TICK_W-1:0]   tick_total;
    logic [3:0]          task_total;
    logic [PERIOD_W-1:0] period_ticks [TASKS];
    logic [PERIOD_W-1:0] elapsed_ticks [TASKS];
    logic                ready_flag [TASKS];
    logic [LOAD_W-1:0]   load_sum;

    task automatic queue_word(input logic acc, input logic valid,
                              input logic [TASK_IDX_W-1:0] idx, input logic lst);
        sched_word_t w;
        w.accepted      = acc;
        w.task_valid    = valid;
        w.task_index    = idx;
        w.last          = lst;
        w.seconds       = tick_total[TICK_W-1:SEC_SHIFT];
        w.load_estimate = load_sum;
        due_words.push_back(w);
    endtask

    task automatic advance_schedule(input logic [OP_W-1:0] op,
                                    input logic [INTERVAL_MS_W-1:0] ms);
        logic [31:0] scaled;
        int          found[$];
        case (op)
            OP_TICK: begin
                tick_total = tick_total + 1'b1;
                for (int i = 0; i < int'(task_total); i++) begin
                    elapsed_ticks[i] = elapsed_ticks[i] + 1'b1;
                    if (elapsed_ticks[i] >= period_ticks[i]) begin
                        elapsed_ticks[i] = '0;
                        ready_flag[i]    = 1'b1;
                    end
                end
                queue_word(1'b0, 1'b0, '0, 1'b1);
            end
            OP_ADD: begin
                if (int'(task_total) >= TASKS) begin
                    queue_word(1'b0, 1'b0, '0, 1'b1);
                end else begin
                    // round to nearest tick at full width
                    scaled = {16'd0, ms} * 32'd16 + 32'd62;
                    period_ticks[task_total]  = PERIOD_W'(scaled / 32'd125);
                    elapsed_ticks[task_total] = '0;
                    ready_flag[task_total]    = 1'b0;
                    queue_word(1'b1, 1'b0, TASK_IDX_W'(task_total), 1'b1);
                    task_total = task_total + 1'b1;
                end
            end
            OP_SERVICE: begin
                for (int i = 0; i < int'(task_total) && found.size() < MAX_DISPATCH; i++) begin
                    if (ready_flag[i]) begin
                        ready_flag[i] = 1'b0;
                        found.push_back(i);
                    end
                end
                load_sum = load_sum + LOAD_BASE + LOAD_PER_TASK * task_total;
                if (found.size() == 0) begin
                    queue_word(1'b0, 1'b0, '0, 1'b1);
                end else begin
                    foreach (found[k])
                        queue_word(1'b0, 1'b1, TASK_IDX_W'(found[k]), k == found.size() - 1);
                end
            end
            default: begin
                queue_word(1'b0, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        sched_word_t w;
        if (due_words.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
        end else begin
            w = due_words.pop_front();
            check_field("accepted", w.accepted, m_accepted);
            check_field("task_valid", w.task_valid, m_task_valid);
            check_field("task_index", w.task_index, m_task_index);
            check_field("last", w.last, m_last);
            check_field("seconds", w.seconds, m_seconds);
            check_field("load_estimate", w.load_estimate, m_load_estimate);
        end
    endtask

    initial mismatches = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_total = '0;
            task_total = '0;
            load_sum   = '0;
            for (int i = 0; i < TASKS; i++) begin
                period_ticks[i]  = '0;
                elapsed_ticks[i] = '0;
                ready_flag[i]    = 1'b0;
            end
            due_words.delete();
        end else begin
            if (s_valid && s_ready)
                advance_schedule(s_op, s_interval_ms);
            if (m_valid && m_ready)
                check_word();
        end
        fail_count    <= mismatches;
        words_pending <= due_words.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the periodic task tick scheduler with a directed opening (empty
// table, zero and largest periods, table full, unused op) and then a random
// mix of ticks, services, adds and unused ops, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pts_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 310;
    localparam int CYCLE_LIMIT  = 200000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op;
    logic [INTERVAL_MS_W-1:0] s_interval_ms;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_accepted;
    logic                     m_task_valid;
    logic [TASK_IDX_W-1:0]    m_task_index;
    logic                     m_last;
    logic [SECONDS_W-1:0]     m_seconds;
    logic [LOAD_W-1:0]        m_load_estimate;

    int   fail_count;
    int   words_pending;
    int   cycle_count;
    logic steady;

    periodic_task_tick_scheduler_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_interval_ms   (s_interval_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_task_valid    (m_task_valid),
        .m_task_index    (m_task_index),
        .m_last          (m_last),
        .m_seconds       (m_seconds),
        .m_load_estimate (m_load_estimate)
    );

    sched_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_interval_ms   (s_interval_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_task_valid    (m_task_valid),
        .m_task_index    (m_task_index),
        .m_last          (m_last),
        .m_seconds       (m_seconds),
        .m_load_estimate (m_load_estimate),
        .fail_count      (fail_count),
        .words_pending   (words_pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // result side stalls at random except during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 18);
    end

    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic [INTERVAL_MS_W-1:0] ms);
        int gap;
        if (!steady && $urandom_range(0, 99) < 18) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_interval_ms <= ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int pick;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_TICK;
        s_interval_ms = '0;
        steady        = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table
        send_word(OP_SERVICE, 16'd0);
        send_word(OP_TICK, 16'd0);
        send_word(OP_UNUSED, 16'hFFFF);
        // zero period, largest period, one tick, rounds down to zero
        send_word(OP_ADD, 16'd0);
        send_word(OP_ADD, 16'hFFFF);
        send_word(OP_ADD, 16'd4);
        send_word(OP_ADD, 16'd3);
        send_word(OP_TICK, 16'd0);
        send_word(OP_SERVICE, 16'd0);
        send_word(OP_SERVICE, 16'd0);
        send_word(OP_ADD, 16'd24);
        repeat (3) send_word(OP_TICK, 16'd0);
        send_word(OP_SERVICE, 16'd0);
        send_word(OP_ADD, 16'd62);
        send_word(OP_ADD, 16'd8);
        send_word(OP_ADD, 16'd16);
        // table now full
        send_word(OP_ADD, 16'd40);
        send_word(OP_TICK, 16'd0);
        send_word(OP_SERVICE, 16'd0);
        send_word(OP_UNUSED, 16'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady <= (n >= 120 && n < 200);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_word(OP_TICK, 16'($urandom));
            else if (pick < 80)
                send_word(OP_SERVICE, 16'($urandom));
            else if (pick < 92)
                send_word(OP_ADD, 16'($urandom));
            else
                send_word(OP_UNUSED, 16'($urandom));
        end
        s_valid <= 1'b0;
        steady  <= 1'b0;

        // let the checker count the last accepted word before waiting on it
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/pts_pkg.sv
design/pts_period_conv.sv
design/periodic_task_tick_scheduler_top.sv
tb/sched_checker.sv
tb/tb.sv
